[design/rwau_pkg.sv]
// Shared constants, codes and types of the range-wrapping arithmetic unit.
package rwau_pkg;

   localparam int unsigned CMD_WIDTH       = 4;
   localparam int unsigned DATA_WIDTH      = 16;
   localparam int unsigned ERR_WIDTH       = 3;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned WIDE_WIDTH      = 32;
   localparam int unsigned DIV_WIDTH       = 33;
   localparam int unsigned SPAN_WIDTH      = 17;
   localparam int unsigned DIV_COUNT_WIDTH = $clog2(DIV_WIDTH + 1);

   localparam logic signed [DATA_WIDTH-1:0] RANGE_LOW_RESET  = 16'sd1;
   localparam logic signed [DATA_WIDTH-1:0] RANGE_HIGH_RESET = 16'sd12;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_LOAD       = 4'd0,
      CMD_ADD        = 4'd1,
      CMD_SUB        = 4'd2,
      CMD_MUL        = 4'd3,
      CMD_DIV        = 4'd4,
      CMD_MOD        = 4'd5,
      CMD_AND        = 4'd6,
      CMD_OR         = 4'd7,
      CMD_XOR        = 4'd8,
      CMD_SHL        = 4'd9,
      CMD_SHR        = 4'd10,
      CMD_NOT        = 4'd11,
      CMD_COMPLEMENT = 4'd12
   } cmd_type;

   typedef enum logic [ERR_WIDTH-1:0] {
      ERR_NONE            = 3'd0,
      ERR_ZERO_DIVISOR    = 3'd1,
      ERR_NO_QUOTIENT     = 3'd2,
      ERR_REMAINDER_RANGE = 3'd3,
      ERR_BAD_SHIFT       = 3'd4
   } err_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_RANGE_LOW  = 2'd0,
      CSR_RANGE_HIGH = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WRAP_SUB,
      ST_WRAP_START,
      ST_WRAP_WAIT,
      ST_DIV_WAIT,
      ST_MOD_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [DIV_WIDTH-1:0]  dividend;
      logic [SPAN_WIDTH-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DIV_WIDTH-1:0]  quotient;
      logic [SPAN_WIDTH-1:0] remainder;
   } div_rsp_type;

endpackage

[design/rwau_if.sv]
// Channel interfaces of the range-wrapping arithmetic unit: command, result and register write.
interface rwau_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [rwau_pkg::CMD_WIDTH-1:0]        cmd;
   logic signed [rwau_pkg::DATA_WIDTH-1:0] operand;

   modport source (output valid, cmd, operand, input ready);
   modport sink   (input valid, cmd, operand, output ready);
endinterface

interface rwau_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [rwau_pkg::DATA_WIDTH-1:0] position_out;
   logic [rwau_pkg::ERR_WIDTH-1:0]        error_code;

   modport source (output valid, position_out, error_code, input ready);
   modport sink   (input valid, position_out, error_code, output ready);
endinterface

interface rwau_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [rwau_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [rwau_pkg::DATA_WIDTH-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[design/rwau_div.sv]
// Iterative restoring divider, one quotient bit per cycle, for wrap, div and mod.
module rwau_div (
   input  logic                  clock,
   input  logic                  reset,
   input  rwau_pkg::div_req_type div_req,
   output rwau_pkg::div_rsp_type div_rsp
);

   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [rwau_pkg::DIV_COUNT_WIDTH-1:0] count_ff, count_in;
   logic [rwau_pkg::DIV_WIDTH-1:0]       quo_ff, quo_in;
   logic [rwau_pkg::SPAN_WIDTH-1:0]      rem_ff, rem_in;
   logic [rwau_pkg::SPAN_WIDTH-1:0]      divisor_ff, divisor_in;
   logic [rwau_pkg::SPAN_WIDTH:0]        rem_shift;
   logic [rwau_pkg::SPAN_WIDTH:0]        trial;
   logic                                 fits;

   always_comb begin
      rem_shift  = {rem_ff, quo_ff[rwau_pkg::DIV_WIDTH-1]};
      trial      = rem_shift - {1'b0, divisor_ff};
      fits       = rem_shift >= {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         quo_in     = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
         count_in   = rwau_pkg::DIV_COUNT_WIDTH'(rwau_pkg::DIV_WIDTH);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[rwau_pkg::DIV_WIDTH-2:0], fits};
         rem_in   = fits ? trial[rwau_pkg::SPAN_WIDTH-1:0]
                         : rem_shift[rwau_pkg::SPAN_WIDTH-1:0];
         count_in = count_ff - rwau_pkg::DIV_COUNT_WIDTH'(1);
         if (count_ff == rwau_pkg::DIV_COUNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

`ifndef SYNTHESIS
   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider restarted while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a run");

   a_count_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> count_ff != '0)
      else $error("divider busy with exhausted count");
`endif

endmodule

[design/range_wrapping_arithmetic_unit.sv]
// Range-wrapping arithmetic unit: holds a position inside range_low..range_high and applies
// one command per beat, wrapping the result back into the range (div and mod results are
// checked against it instead; div with a negative divisor wraps too). Commands are taken one
// at a time; req ready is high only while no command is at work. The wrap modulo comes from
// the 33-step iterative divider, which div and mod also use; div with a negative divisor runs
// it twice, while commands that fail early (zero divisor, bad shift) and unused codes skip it.
// The result sits in an output register, so the next command is accepted while it waits.
// Register writes are taken in any cycle and must only be issued while the unit is idle.
module range_wrapping_arithmetic_unit (
   input logic          clock,
   input logic          reset,
   rwau_req_if.sink     req_if,
   rwau_rsp_if.source   rsp_if,
   rwau_csr_if.sink     csr_if
);

   rwau_pkg::state_type                   state_ff, state_in;
   logic [rwau_pkg::CMD_WIDTH-1:0]        cmd_ff, cmd_in;
   logic signed [rwau_pkg::DATA_WIDTH-1:0] op_ff, op_in;
   logic signed [rwau_pkg::WIDE_WIDTH-1:0] n_ff, n_in;
   logic signed [rwau_pkg::DIV_WIDTH-1:0]  diff_ff, diff_in;
   logic signed [rwau_pkg::SPAN_WIDTH:0]   span_ff, span_in;
   logic signed [rwau_pkg::DATA_WIDTH-1:0] res_ff, res_in;
   logic [rwau_pkg::ERR_WIDTH-1:0]        err_ff, err_in;
   logic signed [rwau_pkg::DATA_WIDTH-1:0] position_ff, position_in;
   logic signed [rwau_pkg::DATA_WIDTH-1:0] range_low_ff, range_low_in;
   logic signed [rwau_pkg::DATA_WIDTH-1:0] range_high_ff, range_high_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic signed [rwau_pkg::DATA_WIDTH-1:0] rsp_pos_ff, rsp_pos_in;
   logic [rwau_pkg::ERR_WIDTH-1:0]        rsp_err_ff, rsp_err_in;

   rwau_pkg::div_req_type                 div_req;
   rwau_pkg::div_rsp_type                 div_rsp;

   logic signed [rwau_pkg::WIDE_WIDTH-1:0] p_ext, o_ext, hi_ext, product;
   logic signed [rwau_pkg::SPAN_WIDTH-1:0] lo17, hi17, q17, r17;
   logic [rwau_pkg::SPAN_WIDTH-1:0]       quo17, wrap_rem;
   logic [rwau_pkg::DATA_WIDTH-1:0]       p_mag, o_mag;
   logic                                  bad_shift;
   logic                                  rsp_advance;

   rwau_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign product     = p_ext * o_ext;
   assign p_ext       = {{16{position_ff[15]}}, position_ff};
   assign o_ext       = {{16{op_ff[15]}}, op_ff};
   assign hi_ext      = {{16{range_high_ff[15]}}, range_high_ff};
   assign lo17        = {range_low_ff[15], range_low_ff};
   assign hi17        = {range_high_ff[15], range_high_ff};
   assign p_mag       = position_ff[15] ? (16'd0 - position_ff) : position_ff;
   assign o_mag       = op_ff[15] ? (16'd0 - op_ff) : op_ff;
   assign bad_shift   = op_ff[15] || (op_ff[14:5] != '0);
   assign quo17       = div_rsp.quotient[rwau_pkg::SPAN_WIDTH-1:0];
   assign q17         = position_ff[15] ? (17'd0 - quo17) : quo17;
   assign r17         = position_ff[15] ? (17'd0 - div_rsp.remainder) : div_rsp.remainder;
   assign wrap_rem    = (diff_ff[rwau_pkg::DIV_WIDTH-1] && div_rsp.remainder != '0)
                      ? (span_ff[rwau_pkg::SPAN_WIDTH-1:0] - div_rsp.remainder)
                      : div_rsp.remainder;
   assign rsp_advance = !rsp_valid_ff || rsp_if.ready;

   // sequencer
   always_comb begin
      state_in         = state_ff;
      cmd_in           = cmd_ff;
      op_in            = op_ff;
      n_in             = n_ff;
      diff_in          = diff_ff;
      span_in          = span_ff;
      res_in           = res_ff;
      err_in           = err_ff;
      position_in      = position_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_if.ready;
      rsp_pos_in       = rsp_pos_ff;
      rsp_err_in       = rsp_err_ff;
      div_req.start    = 1'b0;
      div_req.dividend = {17'd0, p_mag};
      div_req.divisor  = {1'b0, o_mag};

      case (state_ff)
         rwau_pkg::ST_IDLE: begin
            if (req_if.valid) begin
               cmd_in   = req_if.cmd;
               op_in    = req_if.operand;
               state_in = rwau_pkg::ST_EXEC;
            end
         end
         rwau_pkg::ST_EXEC: begin
            err_in   = rwau_pkg::ERR_NONE;
            res_in   = position_ff;
            state_in = rwau_pkg::ST_WRAP_SUB;
            case (cmd_ff)
               rwau_pkg::CMD_LOAD:       n_in = o_ext;
               rwau_pkg::CMD_ADD:        n_in = p_ext + o_ext;
               rwau_pkg::CMD_SUB:        n_in = p_ext - o_ext;
               rwau_pkg::CMD_MUL:        n_in = product;
               rwau_pkg::CMD_AND:        n_in = p_ext & o_ext;
               rwau_pkg::CMD_OR:         n_in = p_ext | o_ext;
               rwau_pkg::CMD_XOR:        n_in = p_ext ^ o_ext;
               rwau_pkg::CMD_NOT:        n_in = ~p_ext;
               rwau_pkg::CMD_COMPLEMENT: n_in = hi_ext - p_ext;
               rwau_pkg::CMD_SHL: begin
                  n_in = p_ext << op_ff[4:0];
                  if (bad_shift) begin
                     err_in   = rwau_pkg::ERR_BAD_SHIFT;
                     state_in = rwau_pkg::ST_DONE;
                  end
               end
               rwau_pkg::CMD_SHR: begin
                  n_in = p_ext >>> op_ff[4:0];
                  if (bad_shift) begin
                     err_in   = rwau_pkg::ERR_BAD_SHIFT;
                     state_in = rwau_pkg::ST_DONE;
                  end
               end
               rwau_pkg::CMD_DIV: begin
                  if (op_ff == '0) begin
                     err_in   = rwau_pkg::ERR_ZERO_DIVISOR;
                     state_in = rwau_pkg::ST_DONE;
                  end else begin
                     div_req.start = 1'b1;
                     state_in      = rwau_pkg::ST_DIV_WAIT;
                  end
               end
               rwau_pkg::CMD_MOD: begin
                  if (op_ff == '0) begin
                     err_in   = rwau_pkg::ERR_ZERO_DIVISOR;
                     state_in = rwau_pkg::ST_DONE;
                  end else if (op_ff > position_ff) begin
                     state_in = rwau_pkg::ST_DONE;
                  end else begin
                     div_req.start = 1'b1;
                     state_in      = rwau_pkg::ST_MOD_WAIT;
                  end
               end
               default: state_in = rwau_pkg::ST_DONE;
            endcase
         end
         rwau_pkg::ST_WRAP_SUB: begin
            diff_in  = {n_ff[31], n_ff} - {{17{range_low_ff[15]}}, range_low_ff};
            span_in  = {{2{range_high_ff[15]}}, range_high_ff}
                     - {{2{range_low_ff[15]}}, range_low_ff} + 18'sd1;
            state_in = rwau_pkg::ST_WRAP_START;
         end
         rwau_pkg::ST_WRAP_START: begin
            if (span_ff[rwau_pkg::SPAN_WIDTH] || span_ff == '0) begin
               res_in   = range_low_ff;
               state_in = rwau_pkg::ST_DONE;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = diff_ff[rwau_pkg::DIV_WIDTH-1]
                                ? (33'd0 - diff_ff) : diff_ff;
               div_req.divisor  = span_ff[rwau_pkg::SPAN_WIDTH-1:0];
               state_in         = rwau_pkg::ST_WRAP_WAIT;
            end
         end
         rwau_pkg::ST_WRAP_WAIT: begin
            if (div_rsp.done) begin
               res_in   = range_low_ff + wrap_rem[rwau_pkg::DATA_WIDTH-1:0];
               state_in = rwau_pkg::ST_DONE;
            end
         end
         rwau_pkg::ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.remainder != '0 || range_low_ff > range_high_ff
                   || q17 < lo17 || q17 > hi17) begin
                  err_in   = rwau_pkg::ERR_NO_QUOTIENT;
                  state_in = rwau_pkg::ST_DONE;
               end else if (op_ff[15]) begin
                  n_in     = hi_ext - {{15{q17[16]}}, q17};
                  state_in = rwau_pkg::ST_WRAP_SUB;
               end else begin
                  res_in   = q17[rwau_pkg::DATA_WIDTH-1:0];
                  state_in = rwau_pkg::ST_DONE;
               end
            end
         end
         rwau_pkg::ST_MOD_WAIT: begin
            if (div_rsp.done) begin
               if (r17 < lo17 || r17 > hi17) begin
                  err_in = rwau_pkg::ERR_REMAINDER_RANGE;
               end else begin
                  res_in = r17[rwau_pkg::DATA_WIDTH-1:0];
               end
               state_in = rwau_pkg::ST_DONE;
            end
         end
         rwau_pkg::ST_DONE: begin
            if (rsp_advance) begin
               if (err_ff == rwau_pkg::ERR_NONE) begin
                  position_in = res_ff;
                  rsp_pos_in  = res_ff;
               end else begin
                  rsp_pos_in  = position_ff;
               end
               rsp_err_in   = err_ff;
               rsp_valid_in = 1'b1;
               state_in     = rwau_pkg::ST_IDLE;
            end
         end
         default: state_in = rwau_pkg::ST_IDLE;
      endcase
   end

   // register writes
   always_comb begin
      range_low_in  = range_low_ff;
      range_high_in = range_high_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            rwau_pkg::CSR_RANGE_LOW:  range_low_in  = csr_if.data;
            rwau_pkg::CSR_RANGE_HIGH: range_high_in = csr_if.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rwau_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         position_ff   <= rwau_pkg::RANGE_LOW_RESET;
         range_low_ff  <= rwau_pkg::RANGE_LOW_RESET;
         range_high_ff <= rwau_pkg::RANGE_HIGH_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         position_ff   <= position_in;
         range_low_ff  <= range_low_in;
         range_high_ff <= range_high_in;
      end
      cmd_ff     <= cmd_in;
      op_ff      <= op_in;
      n_ff       <= n_in;
      diff_ff    <= diff_in;
      span_ff    <= span_in;
      res_ff     <= res_in;
      err_ff     <= err_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign req_if.ready        = state_ff == rwau_pkg::ST_IDLE;
   assign csr_if.ready        = 1'b1;
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.position_out = rsp_pos_ff;
   assign rsp_if.error_code   = rsp_err_ff;

`ifndef SYNTHESIS
   a_error_holds_position: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rwau_pkg::ST_DONE && rsp_advance && err_ff != rwau_pkg::ERR_NONE)
      |=> position_ff == $past(position_ff))
      else $error("failed command changed the position");

   a_result_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rwau_pkg::ST_DONE && err_ff == rwau_pkg::ERR_NONE
       && cmd_ff <= rwau_pkg::CMD_COMPLEMENT && cmd_ff != rwau_pkg::CMD_MOD
       && range_low_ff <= range_high_ff)
      |-> (res_ff >= range_low_ff && res_ff <= range_high_ff))
      else $error("wrapped result outside the range");

   a_wait_has_divider: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rwau_pkg::ST_WRAP_WAIT || state_ff == rwau_pkg::ST_DIV_WAIT
       || state_ff == rwau_pkg::ST_MOD_WAIT)
      |-> (div_rsp.busy || div_rsp.done))
      else $error("waiting on an idle divider");
`endif

endmodule
